// ===== design/che_pkg.sv =====
package che_pkg;

  // field widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned SelW   = 3;
  localparam int unsigned OutW   = 48;

  // element length magnitude and factor magnitude widths
  localparam int unsigned LenW = 32;
  localparam int unsigned FacW = 40;
  localparam int unsigned MagW = 36;

  // product widths
  localparam int unsigned Prod2W = 2 * MagW;
  localparam int unsigned ProdW  = 3 * MagW;
  localparam int unsigned Len2W  = 2 * LenW;
  localparam int unsigned DenW   = 3 * LenW;

  // third derivative constants
  localparam logic signed [FacW-1:0] KTwelve    = FacW'(12);
  localparam logic signed [FacW-1:0] KSix       = FacW'(6);
  localparam logic signed [FacW-1:0] KNegTwelve = -FacW'(12);

  // shape function and order codes, basis * 4 + order
  typedef enum logic [4:0] {
    SEL_N1_D0 = 5'd4,  SEL_N1_D1 = 5'd5,  SEL_N1_D2 = 5'd6,  SEL_N1_D3 = 5'd7,
    SEL_N2_D0 = 5'd8,  SEL_N2_D1 = 5'd9,  SEL_N2_D2 = 5'd10, SEL_N2_D3 = 5'd11,
    SEL_N3_D0 = 5'd12, SEL_N3_D1 = 5'd13, SEL_N3_D2 = 5'd14, SEL_N3_D3 = 5'd15,
    SEL_N4_D0 = 5'd16, SEL_N4_D1 = 5'd17, SEL_N4_D2 = 5'd18, SEL_N4_D3 = 5'd19
  } sel_e;

  // classified item between front and back
  typedef struct packed {
    logic [MagW-1:0] m0;
    logic [MagW-1:0] m1;
    logic [MagW-1:0] m2;
    logic [LenW-1:0] len;
    logic            odd;
    logic [2:0]      ksel;
    logic            neg;
    logic            kill;
    logic            zl;
  } front_t;

  // one result
  typedef struct packed {
    logic [OutW-1:0] value;
    logic            zl;
    logic            sat;
  } result_t;

  // per item flags carried down the back pipeline
  typedef struct packed {
    logic neg;
    logic kill;
    logic zl;
  } ctl_t;

endpackage

// ===== design/che_queue.sv =====
module che_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_d  = do_push ? wr_q + AW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/che_front.sv =====
module che_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic signed [che_pkg::CoordW-1:0] left_node_i,
  input  logic signed [che_pkg::CoordW-1:0] right_node_i,
  input  logic [che_pkg::SelW-1:0]        basis_index_i,
  input  logic [che_pkg::SelW-1:0]        derivative_order_i,
  input  logic signed [che_pkg::CoordW-1:0] eval_point_i,
  output logic                            out_valid_o,
  output che_pkg::front_t                 out_data_o,
  input  logic                            out_ready_i
);

  import che_pkg::*;

  logic                   vld_q, vld_d;
  front_t                 data_q, data_d;
  logic                   accept;
  logic signed [FacW-1:0] x1, x2, xp, hd, h, d1, d2, f0, f1, f2;
  logic [4:0]             code;

  assign full_o      = vld_q && !out_ready_i;
  assign accept      = push_i && !full_o;
  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

  // classify the item and form the three factors
  always_comb begin
    x1   = FacW'(left_node_i);
    x2   = FacW'(right_node_i);
    xp   = FacW'(eval_point_i);
    hd   = x2 - x1;
    h    = hd[FacW-1] ? -hd : hd;
    d1   = xp - x1;
    d2   = xp - x2;
    code = {basis_index_i[2:0], 2'b00} + {2'b00, derivative_order_i};
    f0   = FacW'(1);
    f1   = FacW'(1);
    f2   = FacW'(1);
    case (code)
      SEL_N1_D0: begin f0 = d2; f1 = d2; f2 = 2 * d1 + h; end
      SEL_N1_D1: begin f0 = 2 * d2; f1 = d2 + 2 * d1 + h; end
      SEL_N1_D2: begin f0 = 2 * (4 * d2 + 2 * d1 + h); end
      SEL_N1_D3: begin f0 = KTwelve; end
      SEL_N2_D0: begin f0 = d1; f1 = d2; f2 = d2; end
      SEL_N2_D1: begin f0 = d2; f1 = 2 * d1 + d2; end
      SEL_N2_D2: begin f0 = 4 * d2 + 2 * d1; end
      SEL_N2_D3: begin f0 = KSix; end
      SEL_N3_D0: begin f0 = d1; f1 = d1; f2 = h - 2 * d2; end
      SEL_N3_D1: begin f0 = 2 * d1; f1 = h - d1 - 2 * d2; end
      SEL_N3_D2: begin f0 = 2 * (h - 4 * d1 - 2 * d2); end
      SEL_N3_D3: begin f0 = KNegTwelve; end
      SEL_N4_D0: begin f0 = d2; f1 = d1; f2 = d1; end
      SEL_N4_D1: begin f0 = d1; f1 = d1 + 2 * d2; end
      SEL_N4_D2: begin f0 = 2 * (2 * d1 + d2); end
      default:   begin f0 = KSix; end
    endcase
    data_d.m0   = MagW'(f0[FacW-1] ? -f0 : f0);
    data_d.m1   = MagW'(f1[FacW-1] ? -f1 : f1);
    data_d.m2   = MagW'(f2[FacW-1] ? -f2 : f2);
    data_d.neg  = f0[FacW-1] ^ f1[FacW-1] ^ f2[FacW-1];
    data_d.len  = LenW'(h);
    data_d.odd  = basis_index_i[0];
    data_d.ksel = derivative_order_i + 3'(basis_index_i[0]);
    data_d.zl   = (h == '0);
    data_d.kill = (h == '0) || (basis_index_i == '0) || (basis_index_i > 3'd4)
                  || (derivative_order_i > 3'd3);
    vld_d       = accept || (vld_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // item register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== design/che_back.sv =====
module che_back #(
  parameter int unsigned COORD_FRAC_BITS = 16,
  parameter int unsigned OUT_FRAC_BITS   = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  che_pkg::front_t  in_data_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output che_pkg::result_t out_data_o,
  input  logic             out_ready_i
);

  import che_pkg::*;

  localparam int unsigned CF   = COORD_FRAC_BITS;
  localparam int unsigned OF   = OUT_FRAC_BITS;
  localparam int unsigned SMAX = 3 * CF + OF;
  localparam int unsigned DSH  = (CF > OF) ? CF - OF : 0;
  localparam int unsigned NW   = ProdW + SMAX;
  localparam int unsigned DW   = DenW + DSH;
  localparam int unsigned QW   = OutW;
  localparam int unsigned HW   = NW - QW;
  localparam int unsigned CW   = (HW > DW) ? HW : DW;

  logic adv;

  // stage 1: first products
  logic              s1_vld_q;
  ctl_t              s1_ctl_q;
  logic [MagW-1:0]   s1_m2_q;
  logic [LenW-1:0]   s1_len_q;
  logic              s1_odd_q;
  logic [2:0]        s1_ksel_q;
  logic [Prod2W-1:0] s1_p_q;
  logic [Len2W-1:0]  s1_hh_q;

  // stage 2: partial products, low and high halves
  logic              s2_vld_q;
  ctl_t              s2_ctl_q;
  logic [2:0]        s2_ksel_q;
  logic              s2_odd_q;
  logic [Prod2W-1:0] s2_plo_q;
  logic [Prod2W-1:0] s2_phi_q;
  logic [Len2W-1:0]  s2_dlo_q;
  logic [Len2W-1:0]  s2_dhi_q;
  logic [Len2W-1:0]  s2_hh_q;

  // stage 3: full products
  logic              s3_vld_q;
  ctl_t              s3_ctl_q;
  logic [2:0]        s3_ksel_q;
  logic [ProdW-1:0]  s3_p_q;
  logic [DenW-1:0]   s3_den_q;

  // divider stages
  logic              dv_vld_q [QW+1];
  ctl_t              dv_ctl_q [QW+1];
  logic              dv_ovf_q [QW+1];
  logic [QW-1:0]     dv_n_q   [QW+1];
  logic [DW-1:0]     dv_d_q   [QW+1];
  logic [DW-1:0]     dv_r_q   [QW+1];
  logic [QW-1:0]     dv_q_q   [QW+1];

  logic [NW-1:0]     num0;
  logic [DW-1:0]     den0;
  logic              ovf0;
  logic [DW-1:0]     r_nx     [QW];
  logic [QW-1:0]     q_nx     [QW];

  logic              rnd;
  logic [QW:0]       mag, lim;
  logic              sat;

  assign adv        = out_ready_i;
  assign in_ready_o = adv;

  // scale numerator or denominator by the fixed point shift
  always_comb begin
    int sh;
    num0 = NW'(s3_p_q);
    den0 = DW'(s3_den_q);
    for (int j = 0; j < 5; j++) begin
      sh = j * int'(CF) + int'(OF) - int'(CF);
      if (s3_ksel_q == 3'(j)) begin
        if (sh >= 0) begin
          num0 = NW'(s3_p_q) << sh;
        end else begin
          den0 = DW'(s3_den_q) << (-sh);
        end
      end
    end
    ovf0 = (CW'(num0[NW-1:QW]) >= CW'(den0));
  end

  // one quotient bit per stage
  always_comb begin
    logic [DW:0] t;
    for (int i = 0; i < QW; i++) begin
      t = {dv_r_q[i], dv_n_q[i][QW-1-i]};
      if (t >= {1'b0, dv_d_q[i]}) begin
        r_nx[i] = DW'(t - {1'b0, dv_d_q[i]});
        q_nx[i] = {dv_q_q[i][QW-2:0], 1'b1};
      end else begin
        r_nx[i] = t[DW-1:0];
        q_nx[i] = {dv_q_q[i][QW-2:0], 1'b0};
      end
    end
  end

  // round half away from zero and clip
  always_comb begin
    rnd = ({dv_r_q[QW], 1'b0} >= {1'b0, dv_d_q[QW]});
    mag = {1'b0, dv_q_q[QW]} + (QW+1)'(rnd);
    lim = dv_ctl_q[QW].neg ? (QW+1)'(1) << (QW-1) : ((QW+1)'(1) << (QW-1)) - (QW+1)'(1);
    sat = dv_ovf_q[QW] || (mag > lim);
    if (sat) begin
      mag = lim;
    end
    out_valid_o = dv_vld_q[QW];
    if (dv_ctl_q[QW].kill) begin
      out_data_o.value = '0;
      out_data_o.sat   = 1'b0;
    end else begin
      out_data_o.value = dv_ctl_q[QW].neg ? QW'(-mag) : QW'(mag);
      out_data_o.sat   = sat;
    end
    out_data_o.zl = dv_ctl_q[QW].zl;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      for (int i = 0; i <= QW; i++) begin
        dv_vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      dv_vld_q[0] <= s3_vld_q;
      for (int i = 0; i < QW; i++) begin
        dv_vld_q[i+1] <= dv_vld_q[i];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctl_q  <= '{neg: in_data_i.neg, kill: in_data_i.kill, zl: in_data_i.zl};
      s1_m2_q   <= in_data_i.m2;
      s1_len_q  <= in_data_i.len;
      s1_odd_q  <= in_data_i.odd;
      s1_ksel_q <= in_data_i.ksel;
      s1_p_q    <= Prod2W'(in_data_i.m0) * Prod2W'(in_data_i.m1);
      s1_hh_q   <= Len2W'(in_data_i.len) * Len2W'(in_data_i.len);

      s2_ctl_q  <= s1_ctl_q;
      s2_ksel_q <= s1_ksel_q;
      s2_odd_q  <= s1_odd_q;
      s2_plo_q  <= Prod2W'(s1_p_q[MagW-1:0]) * Prod2W'(s1_m2_q);
      s2_phi_q  <= Prod2W'(s1_p_q[Prod2W-1:MagW]) * Prod2W'(s1_m2_q);
      s2_dlo_q  <= Len2W'(s1_hh_q[LenW-1:0]) * Len2W'(s1_len_q);
      s2_dhi_q  <= Len2W'(s1_hh_q[Len2W-1:LenW]) * Len2W'(s1_len_q);
      s2_hh_q   <= s1_hh_q;

      s3_ctl_q  <= s2_ctl_q;
      s3_ksel_q <= s2_ksel_q;
      s3_p_q    <= ProdW'(s2_plo_q) + (ProdW'(s2_phi_q) << MagW);
      s3_den_q  <= s2_odd_q ? DenW'(s2_dlo_q) + (DenW'(s2_dhi_q) << LenW) : DenW'(s2_hh_q);

      dv_ctl_q[0] <= s3_ctl_q;
      dv_ovf_q[0] <= ovf0;
      dv_n_q[0]   <= num0[QW-1:0];
      dv_d_q[0]   <= den0;
      dv_r_q[0]   <= DW'(num0[NW-1:QW]);
      dv_q_q[0]   <= '0;
      for (int i = 0; i < QW; i++) begin
        dv_ctl_q[i+1] <= dv_ctl_q[i];
        dv_ovf_q[i+1] <= dv_ovf_q[i];
        dv_n_q[i+1]   <= dv_n_q[i];
        dv_d_q[i+1]   <= dv_d_q[i];
        dv_r_q[i+1]   <= r_nx[i];
        dv_q_q[i+1]   <= q_nx[i];
      end
    end
  end

endmodule

// ===== design/cubic_hermite_basis_eval_unit.sv =====
// path from the accepting edge to empty falling: front register,
// mid queue, three multiply stages, 49 divider registers and the result queue
// throughput: one item per cycle while no queue is full, one quotient bit resolved
// per stage; the back pipeline freezes only while the result queue is full
// reset: rst_ni clears all queues and valid bits at once; no clearing pass
module cubic_hermite_basis_eval_unit #(
  parameter int unsigned COORD_FRAC_BITS = 16,
  parameter int unsigned OUT_FRAC_BITS   = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic signed [che_pkg::CoordW-1:0] left_node_i,
  input  logic signed [che_pkg::CoordW-1:0] right_node_i,
  input  logic [che_pkg::SelW-1:0]          basis_index_i,
  input  logic [che_pkg::SelW-1:0]          derivative_order_i,
  input  logic signed [che_pkg::CoordW-1:0] eval_point_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [che_pkg::OutW-1:0]   basis_value_o,
  output logic                              zero_length_o,
  output logic                              saturated_o
);

  import che_pkg::*;

  localparam int unsigned MidDepth = 4;
  localparam int unsigned OutDepth = 2;

  logic    fr_valid, fr_ready;
  front_t  fr_data, mid_data;
  logic    mid_full, mid_empty, mid_pop;
  logic    bk_ready, bk_valid, out_full;
  result_t bk_data, out_data;

  assign fr_ready = !mid_full;
  assign mid_pop  = !mid_empty && bk_ready;

  // front: accept and classify
  che_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push),
    .full_o             (full),
    .left_node_i        (left_node_i),
    .right_node_i       (right_node_i),
    .basis_index_i      (basis_index_i),
    .derivative_order_i (derivative_order_i),
    .eval_point_i       (eval_point_i),
    .out_valid_o        (fr_valid),
    .out_data_o         (fr_data),
    .out_ready_i        (fr_ready)
  );

  // queue between front and back
  che_queue #(
    .WIDTH ($bits(front_t)),
    .DEPTH (MidDepth)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (fr_data),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  // back: products, division, rounding
  che_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .OUT_FRAC_BITS   (OUT_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!mid_empty),
    .in_data_i   (mid_data),
    .in_ready_o  (bk_ready),
    .out_valid_o (bk_valid),
    .out_data_o  (bk_data),
    .out_ready_i (!out_full)
  );

  // result queue
  che_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OutDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_valid),
    .data_i  (bk_data),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign basis_value_o = out_data.value;
  assign zero_length_o = out_data.zl;
  assign saturated_o   = out_data.sat;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import che_pkg::*;

  localparam int unsigned CoordFrac = 16;
  localparam int unsigned OutFrac   = 24;
  localparam int          Drain     = 80;
  localparam longint      One       = 64'sd65536;

  typedef struct packed {
    logic [OutW-1:0] value;
    logic            zl;
    logic            sat;
  } shape_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     push;
  logic                     full;
  logic signed [CoordW-1:0] left_node_i;
  logic signed [CoordW-1:0] right_node_i;
  logic [SelW-1:0]          basis_index_i;
  logic [SelW-1:0]          derivative_order_i;
  logic signed [CoordW-1:0] eval_point_i;
  logic                     empty;
  logic                     pop;
  logic signed [OutW-1:0]   basis_value_o;
  logic                     zero_length_o;
  logic                     saturated_o;

  shape_result_t shape_q[$];
  int            err_count = 0;
  int            beat_count = 0;

  cubic_hermite_basis_eval_unit #(
    .COORD_FRAC_BITS(CoordFrac),
    .OUT_FRAC_BITS  (OutFrac)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .left_node_i       (left_node_i),
    .right_node_i      (right_node_i),
    .basis_index_i     (basis_index_i),
    .derivative_order_i(derivative_order_i),
    .eval_point_i      (eval_point_i),
    .empty             (empty),
    .pop               (pop),
    .basis_value_o     (basis_value_o),
    .zero_length_o     (zero_length_o),
    .saturated_o       (saturated_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // exact shape function value: product of factors over h^p, rounded and clipped
  function automatic shape_result_t hermite_shape_value(
    logic signed [CoordW-1:0] x1s, logic signed [CoordW-1:0] x2s,
    logic [SelW-1:0] bi, logic [SelW-1:0] dv, logic signed [CoordW-1:0] xs);
    longint        x1, x2, x, h, d1, d2;
    longint        f[3];
    logic [255:0]  num, den, q, r, lim;
    logic [63:0]   m;
    logic [OutW-1:0] mag;
    int            s, p;
    bit            neg;
    sel_e          sel;
    shape_result_t res;
    x1 = x1s;
    x2 = x2s;
    x  = xs;
    h  = x2 - x1;
    if (h < 0) h = -h;
    d1 = x - x1;
    d2 = x - x2;
    res = '0;
    res.zl = (h == 0);
    if (h == 0 || bi < 1 || bi > 4 || dv > 3) return res;
    f[0] = 1; f[1] = 1; f[2] = 1;
    sel = sel_e'(5'({bi, 2'b00}) + 5'(dv));
    case (sel)
      SEL_N1_D0: begin f[0] = d2; f[1] = d2; f[2] = 2 * d1 + h; end
      SEL_N1_D1: begin f[0] = 2 * d2; f[1] = d2 + 2 * d1 + h; end
      SEL_N1_D2: f[0] = 2 * (4 * d2 + 2 * d1 + h);
      SEL_N1_D3: f[0] = 12;
      SEL_N2_D0: begin f[0] = d1; f[1] = d2; f[2] = d2; end
      SEL_N2_D1: begin f[0] = d2; f[1] = 2 * d1 + d2; end
      SEL_N2_D2: f[0] = 4 * d2 + 2 * d1;
      SEL_N2_D3: f[0] = 6;
      SEL_N3_D0: begin f[0] = d1; f[1] = d1; f[2] = h - 2 * d2; end
      SEL_N3_D1: begin f[0] = 2 * d1; f[1] = h - d1 - 2 * d2; end
      SEL_N3_D2: f[0] = 2 * (h - 4 * d1 - 2 * d2);
      SEL_N3_D3: f[0] = -12;
      SEL_N4_D0: begin f[0] = d2; f[1] = d1; f[2] = d1; end
      SEL_N4_D1: begin f[0] = d1; f[1] = d1 + 2 * d2; end
      SEL_N4_D2: f[0] = 2 * (2 * d1 + d2);
      default:   f[0] = 6;
    endcase
    neg = 1'b0;
    num = 256'd1;
    for (int i = 0; i < 3; i++) begin
      if (f[i] < 0) neg = ~neg;
      m = (f[i] < 0) ? -f[i] : f[i];
      num = num * {192'd0, m};
    end
    p = bi[0] ? 3 : 2;
    den = 256'd1;
    for (int i = 0; i < p; i++) den = den * {192'd0, h[63:0]};
    // shift is never negative for these formats
    s = (p - 3 + int'(dv)) * CoordFrac + OutFrac;
    num = num << s;
    q = num / den;
    r = num % den;
    if ((r << 1) >= den) q = q + 256'd1;
    lim = neg ? (256'd1 << (OutW - 1)) : ((256'd1 << (OutW - 1)) - 256'd1);
    if (q > lim) begin
      q = lim;
      res.sat = 1'b1;
    end
    mag = q[OutW-1:0];
    res.value = neg ? -mag : mag;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at beat %0d: %s got %0d expected %0d", beat_count, what, got, want);
    err_count++;
  endtask

  // one item beat, then an optional gap
  task automatic send_item(logic signed [CoordW-1:0] x1, logic signed [CoordW-1:0] x2,
                           logic [SelW-1:0] bi, logic [SelW-1:0] dv,
                           logic signed [CoordW-1:0] x);
    int gap;
    @(negedge clk_i);
    push               <= 1'b1;
    left_node_i        <= x1;
    right_node_i       <= x2;
    basis_index_i      <= bi;
    derivative_order_i <= dv;
    eval_point_i       <= x;
    do @(posedge clk_i); while (full);
    shape_q.push_back(hermite_shape_value(x1, x2, bi, dv, x));
    case ($urandom_range(0, 9))
      0, 1, 2: gap = $urandom_range(1, 3);
      3:       gap = $urandom_range(10, 40);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // every shape function and order on a unit element, plus edge cases
  task automatic test_directed();
    for (int b = 1; b <= 4; b++)
      for (int d = 0; d <= 3; d++)
        send_item(32'sd0, 32'(One), 3'(b), 3'(d), 32'(One / 3));
    // unhandled basis and order
    send_item(32'sd0, 32'(One), 3'd0, 3'd0, 32'(One / 2));
    send_item(32'sd0, 32'(One), 3'd7, 3'd1, 32'(One / 2));
    send_item(32'sd0, 32'(One), 3'd2, 3'd4, 32'(One / 2));
    send_item(32'sd0, 32'(One), 3'd3, 3'd7, 32'(One / 2));
    // zero length
    send_item(32'sd12345, 32'sd12345, 3'd1, 3'd0, 32'sd7);
    send_item(-32'sd5, -32'sd5, 3'd6, 3'd5, 32'sd7);
    // full range nodes and points, point outside element
    send_item(32'h8000_0000, 32'h7fff_ffff, 3'd1, 3'd0, 32'h7fff_ffff);
    send_item(32'h7fff_ffff, 32'h8000_0000, 3'd4, 3'd1, 32'h8000_0000);
    send_item(32'sd0, 32'sd1, 3'd1, 3'd3, 32'h7fff_ffff);
    send_item(32'sd0, 32'sd1, 3'd3, 3'd2, 32'h8000_0000);
  endtask

  // mostly small elements with points nearby, some wide range noise
  task automatic test_random(int n);
    logic signed [CoordW-1:0] x1, x2, x;
    logic [SelW-1:0]          bi, dv;
    int                       len;
    for (int i = 0; i < n; i++) begin
      x1 = $urandom;
      x2 = $urandom;
      x  = $urandom;
      case ($urandom_range(0, 9))
        0: ;
        1: x2 = x1;
        2: begin
          x2 = x1 + $signed(32'($urandom_range(0, 3))) - 1;
        end
        default: begin
          x1  = $signed(32'($urandom_range(0, 32'h00ff_ffff))) - 32'sh0080_0000;
          len = $urandom_range(1, 32'h0004_0000);
          x2  = $urandom_range(0, 1) ? x1 + len : x1 - len;
          x   = x1 + $signed(32'($urandom_range(0, 3 * len))) - len;
        end
      endcase
      bi = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
      dv = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3));
      send_item(x1, x2, bi, dv, x);
    end
  endtask

  // result side: random stalls, long ones now and then
  initial begin
    int hold;
    pop  = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0:          hold = $urandom_range(20, 60);
          1, 2, 3, 4: hold = $urandom_range(1, 3);
          default:    hold = 0;
        endcase
        pop <= (hold == 0);
      end
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    shape_result_t want;
    if (rst_ni && pop && !empty) begin
      beat_count++;
      if (shape_q.size() == 0) begin
        report_mismatch("unexpected result, value", longint'(basis_value_o), 0);
      end else begin
        want = shape_q.pop_front();
        if (basis_value_o !== want.value)
          report_mismatch("basis_value", longint'(basis_value_o), longint'($signed(want.value)));
        if (zero_length_o !== want.zl)
          report_mismatch("zero_length", longint'(zero_length_o), longint'(want.zl));
        if (saturated_o !== want.sat)
          report_mismatch("saturated", longint'(saturated_o), longint'(want.sat));
      end
    end
  end

  // run limit
  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    push               = 1'b0;
    left_node_i        = '0;
    right_node_i       = '0;
    basis_index_i      = '0;
    derivative_order_i = '0;
    eval_point_i       = '0;
    rst_ni             = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(1630);

    @(negedge clk_i);
    push <= 1'b0;
    wait (shape_q.size() == 0);
    repeat (Drain) @(posedge clk_i);
    if (err_count == 0 && shape_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
